// ===== hw/rtl/pcan_pkg.sv =====
// Package for the pixel class argmax normalizer.
// Holds the register map, the stream field widths and the packing offsets.
// No dependencies.
package pcan_pkg;

    // Configuration register byte addresses
    localparam logic [2:0] REG_NUM_BACKGROUND = 3'd0;
    localparam logic [2:0] REG_NUM_CHANNELS   = 3'd4;

    // Reset values of the registers
    localparam logic [2:0] NUM_BACKGROUND_RST = 3'd5;
    localparam logic [3:0] NUM_CHANNELS_RST   = 4'd8;

    // Stream field geometry
    localparam int IN_LANES   = 8;
    localparam int IN_FIELD_W = 16;
    localparam int NUM_LABELS = 8;
    localparam int LABEL_W    = 3;
    localparam int OUT_W      = 16;
    localparam int IN_DATA_W  = IN_LANES * IN_FIELD_W;
    // label + win confidence + 8 probabilities = 147 bits, padded to 152
    localparam int OUT_USED_W = LABEL_W + (NUM_LABELS + 1) * OUT_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int WIN_LSB    = LABEL_W;
    localparam int PROB_LSB   = LABEL_W + OUT_W;

    typedef logic [LABEL_W-1:0] t_label;
    typedef logic [OUT_W-1:0]   t_out_field;

endpackage

// ===== hw/rtl/pcan_merge.sv =====
// Merge stage: argmax, total sum and per-label sums over all lanes.
// Depends on pcan_pkg.
module pcan_merge #(
    parameter int CONF_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [2:0]                    i_num_bg,
    input  logic [CONF_WIDTH-1:0]         i_conf [pcan_pkg::IN_LANES],
    output pcan_pkg::t_label              o_label,
    output logic [CONF_WIDTH-1:0]         o_maxc,
    output logic [CONF_WIDTH+2:0]         o_sum,
    output logic [CONF_WIDTH+2:0]         o_lsum [pcan_pkg::NUM_LABELS]
);

    localparam int SW = CONF_WIDTH + 3;

    logic [2:0]            nb_eff;
    logic [CONF_WIDTH-1:0] maxc;
    logic [2:0]            win;
    logic [SW-1:0]         sum;
    logic [SW-1:0]         lsum [pcan_pkg::NUM_LABELS];
    pcan_pkg::t_label      lab [pcan_pkg::IN_LANES];
    pcan_pkg::t_label      win_lab;

    logic [CONF_WIDTH-1:0] r_maxc;
    logic [SW-1:0]         r_sum;
    logic [SW-1:0]         r_lsum [pcan_pkg::NUM_LABELS];
    pcan_pkg::t_label      r_label;

    assign nb_eff = (i_num_bg == 3'd0) ? 3'd1 : i_num_bg;

    // Label of each lane: leading background lanes fold into label 0
    always_comb begin
        for (int i = 0; i < pcan_pkg::IN_LANES; i++) begin
            lab[i] = (3'(i) < nb_eff) ? 3'd0 : 3'(3'(i) - nb_eff + 3'd1);
        end
    end

    // First strict maximum; invalid lanes arrive as zero
    always_comb begin
        maxc = '0;
        win  = 3'd0;
        sum  = '0;
        for (int i = 0; i < pcan_pkg::IN_LANES; i++) begin
            if (i_conf[i] > maxc) begin
                maxc = i_conf[i];
                win  = 3'(i);
            end
            sum = sum + SW'(i_conf[i]);
        end
        win_lab = (win < nb_eff) ? 3'd0 : 3'(win - nb_eff + 3'd1);
    end

    // Per-label sums, one adder tree per label
    always_comb begin
        for (int j = 0; j < pcan_pkg::NUM_LABELS; j++) begin
            lsum[j] = '0;
            for (int i = 0; i < pcan_pkg::IN_LANES; i++) begin
                if (lab[i] == 3'(j)) begin
                    lsum[j] = lsum[j] + SW'(i_conf[i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_maxc  <= maxc;
            r_sum   <= sum;
            r_lsum  <= lsum;
            r_label <= win_lab;
        end
    end

    assign o_label = r_label;
    assign o_maxc  = r_maxc;
    assign o_sum   = r_sum;
    assign o_lsum  = r_lsum;

endmodule

// ===== hw/rtl/pcan_div.sv =====
// Pipelined restoring divider lane: floor(num * 2^CONF_WIDTH / den), saturated.
// One quotient bit per stage; num never exceeds den. Depends on pcan_pkg.
module pcan_div #(
    parameter int CONF_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [CONF_WIDTH+2:0]     i_num,
    input  logic [CONF_WIDTH+2:0]     i_den,
    output pcan_pkg::t_out_field      o_quot
);

    localparam int SW    = CONF_WIDTH + 3;
    localparam int STG   = CONF_WIDTH + 1;

    logic [SW-1:0]         r_rem [STG];
    logic [SW-1:0]         r_den [STG];
    logic [STG-1:0]        r_q   [STG];
    logic [CONF_WIDTH-1:0] res;

    genvar k;
    generate
        for (k = 0; k < STG; k++) begin : g_stage
            logic [SW:0]   rem_in;
            logic [SW:0]   diff;
            logic [SW-1:0] den_in;
            logic [STG-1:0] q_in;
            logic          ge;

            if (k == 0) begin : g_first
                assign rem_in = {1'b0, i_num};
                assign den_in = i_den;
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = {r_rem[k-1], 1'b0};
                assign den_in = r_den[k-1];
                assign q_in   = r_q[k-1];
            end

            assign ge   = rem_in >= {1'b0, den_in};
            assign diff = rem_in - {1'b0, den_in};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? diff[SW-1:0] : rem_in[SW-1:0];
                    r_den[k] <= den_in;
                    r_q[k]   <= {q_in[STG-2:0], ge};
                end
            end
        end
    endgenerate

    // Full share saturates; zero denominator gives zero
    always_comb begin
        if (r_den[STG-1] == '0) begin
            res = '0;
        end else if (r_q[STG-1][CONF_WIDTH]) begin
            res = '1;
        end else begin
            res = r_q[STG-1][CONF_WIDTH-1:0];
        end
    end

    generate
        if (CONF_WIDTH >= pcan_pkg::OUT_W) begin : g_trunc
            assign o_quot = res[pcan_pkg::OUT_W-1:0];
        end else begin : g_ext
            assign o_quot = {{(pcan_pkg::OUT_W-CONF_WIDTH){1'b0}}, res};
        end
    endgenerate

endmodule

// ===== hw/rtl/pixel_class_argmax_normalizer_core.sv =====
// Pixel class argmax normalizer, top level.
// Uses pcan_pkg, pcan_merge and pcan_div.
//
// Usage:
//   Input stream s_*: one pixel per transaction, s_tdata holds eight 16-bit
//   confidences (lane 0 in the low bits). Output stream m_*: one result per
//   pixel with the winning label, max/sum and eight per-label shares.
//   APB port: num_background at 0x0, num_channels at 0x4; write only while
//   the pipeline is drained.
// Pipeline: CONF_WIDTH + 3 register stages (one lane capture stage, one merge
//   stage, one divider stage per quotient bit); the capture stage loads at the
//   accepting edge of the input transaction.
// Throughput: one pixel per cycle while m_tready does not stall; each of the
//   nine divider lanes is fully pipelined, so a new pixel enters every cycle.
// Reset: synchronous, clears all valid flags and loads num_background = 5,
//   num_channels = 8.
// Stall: when a result waits and m_tready is low the whole pipeline holds,
//   bubbles included, and s_tready drops in the same cycle.
module pixel_class_argmax_normalizer_core #(
    parameter int LANE_COUNT = 8,
    parameter int CONF_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // conf_lane0..conf_lane7, 16 bits each, lane 0 lowest
    input  logic [pcan_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // winner_label[2:0], win_confidence[18:3], prob_label0..7 16 bits each
    // from bit 19 up, zero pad [151:147]
    output logic [pcan_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int DEPTH = CONF_WIDTH + 3;
    localparam int DSTG  = CONF_WIDTH + 1;
    localparam int SW    = CONF_WIDTH + 3;
    localparam int NL    = pcan_pkg::NUM_LABELS;

    logic [2:0]            r_num_bg;
    logic [3:0]            r_num_ch;
    logic [3:0]            nc_eff;
    logic                  en;
    logic                  cfg_wr;
    logic [DEPTH-1:0]      r_vld;
    logic [CONF_WIDTH-1:0] lane_conf [pcan_pkg::IN_LANES];
    logic [CONF_WIDTH-1:0] r_conf    [pcan_pkg::IN_LANES];
    pcan_pkg::t_label      mrg_label;
    logic [CONF_WIDTH-1:0] mrg_maxc;
    logic [SW-1:0]         mrg_sum;
    logic [SW-1:0]         mrg_lsum  [NL];
    pcan_pkg::t_label      r_lab     [DSTG];
    pcan_pkg::t_out_field  win_q;
    pcan_pkg::t_out_field  prob_q    [NL];

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bg <= pcan_pkg::NUM_BACKGROUND_RST;
            r_num_ch <= pcan_pkg::NUM_CHANNELS_RST;
        end else if (cfg_wr) begin
            if ((paddr & 3'b100) == pcan_pkg::REG_NUM_CHANNELS) begin
                r_num_ch <= pwdata[3:0];
            end else begin
                r_num_bg <= pwdata[2:0];
            end
        end
    end

    always_comb begin
        if ((paddr & 3'b100) == pcan_pkg::REG_NUM_CHANNELS) begin
            prdata = {28'd0, r_num_ch};
        end else begin
            prdata = {29'd0, r_num_bg};
        end
    end

    assign nc_eff = (r_num_ch > 4'(LANE_COUNT)) ? 4'(LANE_COUNT) : r_num_ch;

    // Pipeline advance: move whenever the output slot is free or taken
    assign en       = !r_vld[DEPTH-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], s_tvalid};
        end
    end

    // Lane capture: mask to CONF_WIDTH, zero lanes that are not valid
    genvar g;
    generate
        for (g = 0; g < pcan_pkg::IN_LANES; g++) begin : g_lane
            logic [pcan_pkg::IN_FIELD_W-1:0] raw;
            logic                            use_lane;
            assign raw      = s_tdata[g*pcan_pkg::IN_FIELD_W +: pcan_pkg::IN_FIELD_W];
            assign use_lane = (g < LANE_COUNT) && (4'(g) < nc_eff);
            if (CONF_WIDTH >= pcan_pkg::IN_FIELD_W) begin : g_wide
                assign lane_conf[g] = use_lane ? CONF_WIDTH'(raw) : '0;
            end else begin : g_narrow
                assign lane_conf[g] = use_lane ? raw[CONF_WIDTH-1:0] : '0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_conf <= lane_conf;
        end
    end

    pcan_merge #(
        .CONF_WIDTH (CONF_WIDTH)
    ) u_merge (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_num_bg (r_num_bg),
        .i_conf   (r_conf),
        .o_label  (mrg_label),
        .o_maxc   (mrg_maxc),
        .o_sum    (mrg_sum),
        .o_lsum   (mrg_lsum)
    );

    // Winner label rides beside the divider lanes
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lab[0] <= mrg_label;
            for (int s = 1; s < DSTG; s++) begin
                r_lab[s] <= r_lab[s-1];
            end
        end
    end

    // Nine divider lanes: max share and one per label
    pcan_div #(
        .CONF_WIDTH (CONF_WIDTH)
    ) u_div_win (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (SW'(mrg_maxc)),
        .i_den  (mrg_sum),
        .o_quot (win_q)
    );

    generate
        for (g = 0; g < NL; g++) begin : g_prob
            pcan_div #(
                .CONF_WIDTH (CONF_WIDTH)
            ) u_div (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_num  (mrg_lsum[g]),
                .i_den  (mrg_sum),
                .o_quot (prob_q[g])
            );
        end
    endgenerate

    // Output packing
    always_comb begin
        m_tdata = '0;
        m_tdata[pcan_pkg::LABEL_W-1:0] = r_lab[DSTG-1];
        m_tdata[pcan_pkg::WIN_LSB +: pcan_pkg::OUT_W] = win_q;
        for (int j = 0; j < NL; j++) begin
            m_tdata[pcan_pkg::PROB_LSB + j*pcan_pkg::OUT_W +: pcan_pkg::OUT_W] = prob_q[j];
        end
    end

    // Assertions
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> r_vld[0])
        else $error("accepted pixel not captured");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> (r_vld == $past(r_vld)))
        else $error("pipeline moved while stalled");

    a_zero_share: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (win_q == '0)) |->
            (m_tdata[pcan_pkg::OUT_USED_W-1:pcan_pkg::PROB_LSB] == '0))
        else $error("zero max share with nonzero label share");

endmodule
